/* rtl/vdphp_pkg.sv */
// Shared types and constants for the video processor host port.
package vdphp_pkg;

    // Video memory geometry.
    localparam int VRAM_DEPTH = 16384;
    localparam int VRAM_AW    = 14;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_DATA_RD   = 3'd0;
    localparam logic [2:0] REQ_STATUS_RD = 3'd1;
    localparam logic [2:0] REQ_DATA_WR   = 3'd2;
    localparam logic [2:0] REQ_CTRL_WR   = 3'd3;
    localparam logic [2:0] REQ_LINE_TICK = 3'd4;

    // Modes selected by bits 7..6 of the second control byte.
    localparam logic [1:0] CMD_READ_SETUP  = 2'b00;
    localparam logic [1:0] CMD_WRITE_SETUP = 2'b01;

    // Control register that holds the frame interrupt enable.
    localparam logic [2:0] REG_MODE1 = 3'd1;
    localparam int         IE_BIT    = 5;

    // One input beat.
    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_byte;
    } req_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_level;
        logic       frame_start;
    } rsp_t;

endpackage

/* rtl/vdphp_ram.sv */
// Generic single-port RAM with registered read data.
module vdphp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[addr];
    end

endmodule

/* rtl/vdp_host_port_interface.sv */
// Host port of a tile video processor: data, status and control ports plus line ticks.
//
// An item is taken when start is high and busy is low; its result appears on result
// with done high, registered through exec_reg and then done_reg, and busy drops again
// in that same cycle; no new item is taken while one executes. The read-ahead latch
// is refilled by the registered read of the video memory. After reset the block
// clears the video memory, one byte per cycle, with busy held high.
// Results cannot be held off, so the receiver must take every done beat.
module vdp_host_port_interface
    import vdphp_pkg::*;
#(
    parameter int ACTIVE_LINES = 192,
    parameter int FRAME_LINES  = 262
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t item,
    output logic done,
    output rsp_t result
);

    localparam logic [8:0] ACTIVE_L = 9'(ACTIVE_LINES);
    localparam logic [9:0] FRAME_L  = 10'(FRAME_LINES);

    // Control flow.
    logic               exec_reg;
    logic               fill_reg, fill_next;
    logic               clearing_reg;
    logic [VRAM_AW-1:0] clr_addr_reg;
    req_t               req_reg;

    // Architectural state.
    logic [VRAM_AW-1:0] addr_reg, addr_next;
    logic [7:0]         latch_reg, latch_next;
    logic [7:0]         first_reg, first_next;
    logic               await_reg, await_next;
    logic [8:0]         line_reg, line_next;
    logic               irq_reg, irq_next;
    logic               frame_flag_reg, frame_flag_next;
    logic               ie_reg, ie_next;

    // Result.
    logic               done_reg;
    rsp_t               result_reg, result_next;

    // Memory port from the executing item.
    logic               ex_we;
    logic [VRAM_AW-1:0] ex_addr;
    logic [7:0]         ex_wdata;
    logic               ram_we;
    logic [VRAM_AW-1:0] ram_addr;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;

    logic               accept;
    logic [VRAM_AW-1:0] setup_addr;
    logic [9:0]         line_inc;

    function automatic logic [5:0] item_byte_hi(input logic [7:0] b);
        item_byte_hi = b[5:0];
    endfunction

    assign accept = start && !busy;
    assign busy   = exec_reg || clearing_reg;
    assign done   = done_reg;
    assign result = result_reg;

    assign setup_addr = {item_byte_hi(req_reg.data_byte), first_reg};
    assign line_inc   = {1'b0, line_reg} + 10'd1;

    // Execute the registered request against the current state.
    always_comb
    begin
        addr_next       = addr_reg;
        latch_next      = latch_reg;
        first_next      = first_reg;
        await_next      = await_reg;
        line_next       = line_reg;
        irq_next        = irq_reg;
        frame_flag_next = frame_flag_reg;
        ie_next         = ie_reg;
        fill_next       = 1'b0;
        ex_we           = 1'b0;
        ex_addr         = addr_reg;
        ex_wdata        = req_reg.data_byte;
        result_next     = '0;

        if (exec_reg)
        begin
            case (req_reg.req_type)
                REQ_DATA_RD:
                begin
                    result_next.read_byte = latch_reg;
                    fill_next  = 1'b1;
                    addr_next  = addr_reg + VRAM_AW'(1);
                    await_next = 1'b0;
                end
                REQ_STATUS_RD:
                begin
                    result_next.read_byte = {frame_flag_reg, 7'b0};
                    frame_flag_next = 1'b0;
                    irq_next        = 1'b0;
                    await_next      = 1'b0;
                end
                REQ_DATA_WR:
                begin
                    ex_we      = 1'b1;
                    latch_next = req_reg.data_byte;
                    addr_next  = addr_reg + VRAM_AW'(1);
                    await_next = 1'b0;
                end
                REQ_CTRL_WR:
                begin
                    if (!await_reg)
                    begin
                        first_next = req_reg.data_byte;
                        addr_next  = {addr_reg[VRAM_AW-1:8], req_reg.data_byte};
                        await_next = 1'b1;
                    end
                    else
                    begin
                        await_next = 1'b0;
                        case (req_reg.data_byte[7:6])
                            CMD_READ_SETUP:
                            begin
                                ex_addr   = setup_addr;
                                fill_next = 1'b1;
                                addr_next = setup_addr + VRAM_AW'(1);
                            end
                            CMD_WRITE_SETUP:
                            begin
                                addr_next = setup_addr;
                            end
                            default:
                            begin
                                // Only the interrupt enable of register 1 matters here.
                                if (req_reg.data_byte[2:0] == REG_MODE1)
                                begin
                                    ie_next  = first_reg[IE_BIT];
                                    irq_next = first_reg[IE_BIT] && frame_flag_reg;
                                end
                            end
                        endcase
                    end
                end
                REQ_LINE_TICK:
                begin
                    if (line_reg == ACTIVE_L)
                    begin
                        frame_flag_next = 1'b1;
                        if (ie_reg)
                        begin
                            irq_next = 1'b1;
                        end
                        result_next.frame_start = 1'b1;
                    end
                    if (line_inc >= FRAME_L || line_inc[8:0] == 9'd0)
                    begin
                        line_next = 9'd0;
                    end
                    else
                    begin
                        line_next = line_inc[8:0];
                    end
                end
                default:
                begin
                end
            endcase
            result_next.irq_level = irq_next;
        end

        // The read-ahead latch takes the registered memory word when fill_reg flags a prefetch.
        if (fill_reg)
        begin
            latch_next = ram_rdata;
        end
    end

    // Memory port: the clearing pass owns it after reset.
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = 8'd0;
        end
        else
        begin
            ram_we    = ex_we;
            ram_addr  = ex_addr;
            ram_wdata = ex_wdata;
        end
    end

    vdphp_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Clearing pass over the video memory after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + VRAM_AW'(1);
            if (&clr_addr_reg)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Request capture and sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg <= 1'b0;
            fill_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            exec_reg <= accept;
            fill_reg <= fill_next;
            done_reg <= exec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= item;
        end
        if (exec_reg)
        begin
            result_reg <= result_next;
        end
    end

    // Host-visible state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            latch_reg      <= 8'd0;
            first_reg      <= 8'd0;
            await_reg      <= 1'b0;
            line_reg       <= 9'd0;
            irq_reg        <= 1'b0;
            frame_flag_reg <= 1'b0;
            ie_reg         <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            latch_reg      <= latch_next;
            first_reg      <= first_next;
            await_reg      <= await_next;
            line_reg       <= line_next;
            irq_reg        <= irq_next;
            frame_flag_reg <= frame_flag_next;
            ie_reg         <= ie_next;
        end
    end

    // A taken beat produces exactly one result, through exec_reg and then done_reg.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted beat did not produce a result");

    // Results are never back to back, since busy stays high while an item executes.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // A latch refill always follows an executed request, never the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg |-> $past(exec_reg) && !$past(clearing_reg))
        else $error("latch refill without an executed prefetch");

    // The line counter stays inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, line_reg} < FRAME_L || FRAME_L == 10'd0)
        else $error("line counter left the frame");

    // A frame start with the interrupt enabled raises the interrupt line.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.frame_start && $past(ie_reg, 2) |-> result.irq_level)
        else $error("frame start did not raise the enabled interrupt");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the video processor host port: driver, predictor and monitor.
module tb;
    import vdphp_pkg::*;

    localparam int LINES_SHOWN     = 192;
    localparam int LINES_PER_FRAME = 262;
    localparam int BEAT_TARGET     = 1950;

    // Second control byte mode for a register write (bit 6 is a don't care).
    localparam logic [1:0] CMD_REG_WRITE = 2'b10;

    // A queued host beat, optionally held back until all responses are in.
    typedef struct {
        req_t beat;
        bit   drain;
    } host_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t item  = '0;
    logic busy;
    logic done;
    rsp_t result;

    host_beat_t host_beats[$];
    rsp_t       rsp_due[$];
    int         err_count  = 0;
    int         beat_count = 0;
    bit         hold_next  = 1'b0;
    int         burst_left = 4;
    int         gap_left   = 0;

    // Shadow copy of the host port state.
    logic [7:0]  vram_m [0:VRAM_DEPTH-1];
    logic [7:0]  regs_m [0:7];
    logic [7:0]  stat_m   = '0;
    logic [13:0] addr_m   = '0;
    logic [7:0]  latch_m  = '0;
    logic [7:0]  first_m  = '0;
    logic        second_m = 1'b0;
    logic [8:0]  line_m   = '0;
    logic        irq_m    = 1'b0;

    vdp_host_port_interface #(
        .ACTIVE_LINES(LINES_SHOWN),
        .FRAME_LINES (LINES_PER_FRAME)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .done  (done),
        .result(result)
    );

    always #5 clk = ~clk;

    // Apply one accepted beat to the shadow state and queue the response it causes.
    task automatic host_port_predict(input req_t b);
        rsp_t       r;
        logic [7:0] v;
        begin
            r = '0;
            v = b.data_byte;
            case (b.req_type)
                REQ_DATA_RD:
                begin
                    r.read_byte = latch_m;
                    latch_m     = vram_m[addr_m];
                    addr_m      = addr_m + 14'd1;
                    second_m    = 1'b0;
                end
                REQ_STATUS_RD:
                begin
                    r.read_byte = stat_m;
                    stat_m      = stat_m & 8'h1F;
                    irq_m       = 1'b0;
                    second_m    = 1'b0;
                end
                REQ_DATA_WR:
                begin
                    vram_m[addr_m] = v;
                    latch_m        = v;
                    addr_m         = addr_m + 14'd1;
                    second_m       = 1'b0;
                end
                REQ_CTRL_WR:
                begin
                    if (!second_m)
                    begin
                        first_m  = v;
                        addr_m   = {addr_m[13:8], v};
                        second_m = 1'b1;
                    end
                    else
                    begin
                        second_m = 1'b0;
                        if (v[7:6] == CMD_READ_SETUP)
                        begin
                            addr_m  = {v[5:0], first_m};
                            latch_m = vram_m[addr_m];
                            addr_m  = addr_m + 14'd1;
                        end
                        else if (v[7:6] == CMD_WRITE_SETUP)
                        begin
                            addr_m = {v[5:0], first_m};
                        end
                        else
                        begin
                            regs_m[v[2:0]] = first_m;
                            if (v[2:0] == REG_MODE1)
                                irq_m = first_m[IE_BIT] & stat_m[7];
                        end
                    end
                end
                REQ_LINE_TICK:
                begin
                    if (line_m == LINES_SHOWN)
                    begin
                        stat_m[7] = 1'b1;
                        if (regs_m[REG_MODE1][IE_BIT])
                            irq_m = 1'b1;
                        r.frame_start = 1'b1;
                    end
                    line_m = line_m + 9'd1;
                    if (line_m >= LINES_PER_FRAME || line_m == 9'd0)
                        line_m = '0;
                end
                default:
                begin
                end
            endcase
            r.irq_level = irq_m;
            rsp_due.push_back(r);
        end
    endtask

    // Queue one host beat; unknown request codes do not count toward the target.
    task automatic queue_beat(input logic [2:0] code, input logic [7:0] val);
        host_beat_t hb;
        begin
            hb.beat.req_type  = code;
            hb.beat.data_byte = val;
            hb.drain          = hold_next;
            hold_next         = 1'b0;
            host_beats.push_back(hb);
            if (code <= REQ_LINE_TICK)
                beat_count++;
        end
    endtask

    // Queue a complete control pair.
    task automatic queue_ctrl_pair(input logic [7:0] lo, input logic [7:0] hi);
        begin
            queue_beat(REQ_CTRL_WR, lo);
            queue_beat(REQ_CTRL_WR, hi);
        end
    endtask

    // Driver: present queued beats in bursts with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin : driver
        host_beat_t head;
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                host_port_predict(item);
                void'(host_beats.pop_front());
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (host_beats.size() > 0 &&
                         (!host_beats[0].drain || rsp_due.size() == 0))
                begin
                    head  = host_beats[0];
                    start <= 1'b1;
                    item  <= head.beat;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left   = $urandom_range(1, 12);
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every response beat against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n && done)
        begin
            if (rsp_due.size() == 0)
            begin
                $display("%0t: response beat expected none, actual %h", $time, result);
                err_count++;
            end
            else
            begin
                want = rsp_due.pop_front();
                if (result.read_byte !== want.read_byte)
                begin
                    $display("%0t: read_byte expected %h, actual %h",
                             $time, want.read_byte, result.read_byte);
                    err_count++;
                end
                if (result.irq_level !== want.irq_level)
                begin
                    $display("%0t: irq_level expected %b, actual %b",
                             $time, want.irq_level, result.irq_level);
                    err_count++;
                end
                if (result.frame_start !== want.frame_start)
                begin
                    $display("%0t: frame_start expected %b, actual %b",
                             $time, want.frame_start, result.frame_start);
                    err_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stimulus
        int kind;
        int n;
        for (int i = 0; i < VRAM_DEPTH; i++)
            vram_m[i] = '0;
        for (int i = 0; i < 8; i++)
            regs_m[i] = '0;

        // Directed part: reset values, address extremes and wrap, pairing rules.
        queue_beat(REQ_DATA_RD, 8'h00);
        queue_beat(REQ_STATUS_RD, 8'hFF);
        queue_ctrl_pair(8'hFF, 8'h7F);
        queue_beat(REQ_DATA_WR, 8'hFF);
        queue_beat(REQ_DATA_WR, 8'h00);
        queue_ctrl_pair(8'hFF, 8'h3F);
        queue_beat(REQ_DATA_RD, 8'h00);
        queue_beat(REQ_DATA_RD, 8'hFF);
        queue_ctrl_pair(8'h20, 8'h81);
        // A data read or a status read between the two control bytes restarts the pair.
        queue_beat(REQ_CTRL_WR, 8'hA5);
        queue_beat(REQ_DATA_RD, 8'h00);
        queue_beat(REQ_CTRL_WR, 8'h12);
        queue_beat(REQ_STATUS_RD, 8'h00);
        queue_beat(REQ_CTRL_WR, 8'h00);
        hold_next = 1'b1;
        queue_beat(REQ_CTRL_WR, 8'hC7);
        // Unknown request codes leave the state alone.
        queue_beat(3'd5, 8'hFF);
        queue_beat(3'd6, 8'h00);
        queue_beat(3'd7, 8'hAA);
        queue_beat(REQ_LINE_TICK, 8'hFF);
        queue_beat(REQ_LINE_TICK, 8'h00);

        // Random part: mostly well-formed sequences, some noise and broken pairs.
        while (beat_count < BEAT_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0)
                hold_next = 1'b1;
            case (kind)
                0, 1, 2:
                begin
                    queue_ctrl_pair(8'($urandom_range(0, 255)),
                                    {($urandom_range(0, 1) ? CMD_WRITE_SETUP : CMD_READ_SETUP),
                                     6'($urandom_range(0, 63))});
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        queue_beat($urandom_range(0, 1) ? REQ_DATA_WR : REQ_DATA_RD,
                                   8'($urandom_range(0, 255)));
                end
                3, 4:
                begin
                    n = $urandom_range(1, 150);
                    for (int i = 0; i < n; i++)
                        queue_beat(REQ_LINE_TICK, 8'($urandom_range(0, 255)));
                end
                5:
                begin
                    queue_ctrl_pair(8'($urandom_range(0, 255)),
                                    {CMD_REG_WRITE | 2'($urandom_range(0, 1)),
                                     3'($urandom_range(0, 7)),
                                     ($urandom_range(0, 1) ? REG_MODE1
                                                           : 3'($urandom_range(0, 7)))});
                end
                6:
                begin
                    queue_beat(REQ_STATUS_RD, 8'($urandom_range(0, 255)));
                end
                7:
                begin
                    queue_beat(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    queue_beat(REQ_CTRL_WR, 8'($urandom_range(0, 255)));
                    queue_beat(3'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
                end
            endcase
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (host_beats.size() > 0 || rsp_due.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Run limit.
    initial
    begin
        #6_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
